// ===== sv/kmeq_pkg.sv =====
package kmeq_pkg;

    // default ring depths, handed to the top level parameters
    localparam int KEY_QUEUE_DEPTH_DEF   = 64;
    localparam int MOUSE_QUEUE_DEPTH_DEF = 64;

    // interrupt level of the input controller
    localparam logic [2:0] IRQ_LEVEL = 3'd5;

    // command modes
    localparam logic [2:0] MODE_KEY        = 3'd0;
    localparam logic [2:0] MODE_BTN_PRESS  = 3'd1;
    localparam logic [2:0] MODE_BTN_REL    = 3'd2;
    localparam logic [2:0] MODE_READ_MOUSE = 3'd3;
    localparam logic [2:0] MODE_READ_KEY   = 3'd4;
    localparam logic [2:0] MODE_UPDATE     = 3'd5;
    localparam logic [2:0] MODE_MOTION     = 3'd6;

    // button codes
    localparam logic [1:0] BUTTON_RIGHT  = 2'd0;
    localparam logic [1:0] BUTTON_LEFT   = 2'd1;
    localparam logic [1:0] BUTTON_MIDDLE = 2'd2;

    // button state bits and report constants
    localparam logic [1:0] BTN_BIT_RIGHT = 2'b01;
    localparam logic [1:0] BTN_BIT_LEFT  = 2'b10;
    localparam logic [7:0] KEY_RELEASE   = 8'h80;
    localparam logic [7:0] BTN_MARK      = 8'hf8;

    typedef struct packed {
        logic [2:0]         mode;
        logic [6:0]         scan_code;
        logic               pressed;
        logic [1:0]         button;
        logic signed [15:0] old_x;
        logic signed [15:0] old_y;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [2:0]         cpu_mask_level;
        logic [2:0]         active_level;
    } t_cmd;

    typedef struct packed {
        logic [7:0]         key_code;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic [7:0]         btn_report;
        logic               irq_request;
        logic               grab_toggle;
        logic               overflow;
    } t_result;

endpackage

// ===== sv/keyboard_mouse_event_queue.sv =====
// Keyboard and mouse event queue. One command is taken on every clock edge at
// which start is high; busy never rises, so commands may follow back to back.
// Each command gives exactly one result, shown on o_result for the single cycle
// in which o_done is high, in the cycle after the command was taken. The receiver
// cannot stall: a result not captured in its cycle is gone. Key codes and
// button snapshots sit in two ring memories, each with a registered read port. A
// full ring drops the new entry and flags overflow on that command's result.
module keyboard_mouse_event_queue import kmeq_pkg::*; #(
    parameter int KEY_QUEUE_DEPTH   = KEY_QUEUE_DEPTH_DEF,
    parameter int MOUSE_QUEUE_DEPTH = MOUSE_QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    // command transfer
    logic accept;

    // ring controls
    logic       key_push;
    logic       key_pop;
    logic       key_full;
    logic       key_empty;
    logic [7:0] key_push_data;
    logic [7:0] key_rdata;
    logic       btn_push;
    logic       btn_pop;
    logic       btn_full;
    logic       btn_empty;
    logic [1:0] btn_rdata;

    // controller state
    logic [1:0]  r_btn_state;
    logic [1:0]  n_btn_state;
    logic [15:0] r_acc_x;
    logic [15:0] n_acc_x;
    logic [15:0] r_acc_y;
    logic [15:0] n_acc_y;

    // result stage
    t_result r_res;
    t_result n_res;
    logic    r_done;
    logic    r_key_pop;
    logic    r_btn_pop;

    logic [1:0] btn_mask;
    logic       btn_known;
    logic       pending;

    // no multi-cycle work, so a new command is always welcome
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // right maps to bit 0, left to bit 1; middle and other touch no state
    assign btn_known = (i_cmd.button == BUTTON_RIGHT) || (i_cmd.button == BUTTON_LEFT);
    assign btn_mask  = (i_cmd.button == BUTTON_RIGHT) ? BTN_BIT_RIGHT : BTN_BIT_LEFT;

    assign pending = !key_empty || !btn_empty || (r_acc_x != '0) || (r_acc_y != '0);

    // release sets bit 7 of the key code
    assign key_push_data = i_cmd.pressed ? {1'b0, i_cmd.scan_code}
                                         : ({1'b0, i_cmd.scan_code} | KEY_RELEASE);

    always_comb begin
        n_btn_state = r_btn_state;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_res       = '0;
        key_push    = 1'b0;
        key_pop     = 1'b0;
        btn_push    = 1'b0;
        btn_pop     = 1'b0;
        if (accept) begin
            unique case (i_cmd.mode)
                MODE_KEY: begin
                    key_push       = 1'b1;
                    n_res.overflow = key_full;
                end
                MODE_BTN_PRESS: begin
                    if (btn_known) begin
                        n_btn_state    = r_btn_state | btn_mask;
                        btn_push       = 1'b1;
                        n_res.overflow = btn_full;
                    end else if (i_cmd.button == BUTTON_MIDDLE) begin
                        n_res.grab_toggle = 1'b1;
                    end
                end
                MODE_BTN_REL: begin
                    if (btn_known) begin
                        n_btn_state    = r_btn_state & ~btn_mask;
                        btn_push       = 1'b1;
                        n_res.overflow = btn_full;
                    end
                end
                MODE_READ_MOUSE: begin
                    n_res.mouse_x = i_cmd.old_x + $signed(r_acc_x);
                    n_res.mouse_y = i_cmd.old_y + $signed(r_acc_y);
                    // oldest snapshot if one is queued, else the live state
                    n_res.btn_report = BTN_MARK | {6'b0, r_btn_state};
                    btn_pop = !btn_empty;
                    n_acc_x = '0;
                    n_acc_y = '0;
                end
                MODE_READ_KEY: begin
                    key_pop = !key_empty;
                end
                MODE_UPDATE: begin
                    n_res.irq_request = pending && (IRQ_LEVEL > i_cmd.cpu_mask_level)
                                        && (IRQ_LEVEL > i_cmd.active_level);
                end
                MODE_MOTION: begin
                    n_acc_x = r_acc_x + i_cmd.delta_x;
                    n_acc_y = r_acc_y + i_cmd.delta_y;
                end
                default: begin
                end
            endcase
        end
    end

    kmeq_ring #(
        .DEPTH (KEY_QUEUE_DEPTH),
        .WIDTH (8)
    ) u_key_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (key_push),
        .i_push_data (key_push_data),
        .i_pop       (key_pop),
        .o_full      (key_full),
        .o_empty     (key_empty),
        .o_rdata     (key_rdata)
    );

    // snapshot pushed is the state after this button event
    kmeq_ring #(
        .DEPTH (MOUSE_QUEUE_DEPTH),
        .WIDTH (2)
    ) u_btn_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (btn_push),
        .i_push_data (n_btn_state),
        .i_pop       (btn_pop),
        .o_full      (btn_full),
        .o_empty     (btn_empty),
        .o_rdata     (btn_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_state <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_btn_state <= n_btn_state;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_done      <= accept;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_key_pop <= key_pop;
        r_btn_pop <= btn_pop;
    end

    // merge the registered ring reads into the result
    always_comb begin
        o_result = r_res;
        if (r_key_pop) begin
            o_result.key_code = key_rdata;
        end
        if (r_btn_pop) begin
            o_result.btn_report = BTN_MARK | {6'b0, btn_rdata};
        end
    end

    assign o_done = r_done;

endmodule

// ===== sv/kmeq_ring.sv =====
module kmeq_ring import kmeq_pkg::*; #(
    parameter int DEPTH = KEY_QUEUE_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    n_count;
    logic [SW-1:0]    tail_sum;
    logic [AW-1:0]    wr_addr;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);

    // tail = head + count, wrapped once at the depth
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign wr_addr  = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_push && !o_full) begin
            n_count = r_count + CW'(1);
        end
        if (i_pop && !o_empty) begin
            n_head  = (r_head == LAST_A) ? '0 : r_head + AW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[wr_addr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            o_rdata <= r_mem[r_head];
        end
    end

endmodule

// ===== tb/tb_keyboard_mouse_event_queue.sv =====
`timescale 1ns / 1ps

module tb_keyboard_mouse_event_queue;
    import kmeq_pkg::*;

    // ring depths of the instance under test
    localparam int KQ_DEPTH = KEY_QUEUE_DEPTH_DEF;
    localparam int BQ_DEPTH = MOUSE_QUEUE_DEPTH_DEF;

    // codes the package does not name
    localparam logic [2:0] MODE_NONE    = 3'd7;
    localparam logic [1:0] BUTTON_OTHER = 2'd3;

    // run shape
    localparam int N_RANDOM    = 1150;
    localparam int IDLE_PCT    = 19;
    localparam int QUIET_FIRST = 500;   // random transfers 500..699 go back to back
    localparam int QUIET_LAST  = 700;
    localparam int STALL_LIMIT = 1000;  // cycles with no transfer at all

    // event mix of one random block
    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    // one row of the directed table; want is used only where typed is set
    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_done;
    t_result o_result;

    // typed expectation that travels with the command being offered
    bit      cur_typed;
    t_result cur_want;

    int      n_errors     = 0;
    int      stall_cycles = 0;
    t_result pending_results [$];

    // shadow copy of the queues, buttons and motion
    logic [7:0]  key_ring  [KQ_DEPTH];
    int          key_head  = 0;
    int          key_count = 0;
    logic [1:0]  snap_ring [BQ_DEPTH];
    int          snap_head  = 0;
    int          snap_count = 0;
    logic [1:0]  btn_held   = '0;
    logic [15:0] acc_mx     = '0;
    logic [15:0] acc_my     = '0;

    keyboard_mouse_event_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------
    // shadow model
    // -------------------------------------------------------------------

    // store the current button state; a full ring drops it
    function automatic bit push_snapshot();
        if (snap_count >= BQ_DEPTH)
            return 1'b0;
        snap_ring[(snap_head + snap_count) % BQ_DEPTH] = btn_held;
        snap_count++;
        return 1'b1;
    endfunction

    // apply one command to the shadow state and return its result
    function automatic t_result predict_event(t_cmd c);
        t_result    r;
        logic [7:0] code;
        logic [1:0] btn_bit;
        logic [1:0] snap;
        bit         pending;
        r = '0;
        btn_bit = (c.button == BUTTON_RIGHT) ? BTN_BIT_RIGHT : BTN_BIT_LEFT;
        case (c.mode)
            MODE_KEY: begin
                // release codes carry the top bit
                code = c.pressed ? {1'b0, c.scan_code} : ({1'b0, c.scan_code} | KEY_RELEASE);
                if (key_count >= KQ_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    key_ring[(key_head + key_count) % KQ_DEPTH] = code;
                    key_count++;
                end
            end
            MODE_BTN_PRESS: begin
                if (c.button == BUTTON_RIGHT || c.button == BUTTON_LEFT) begin
                    btn_held = btn_held | btn_bit;
                    r.overflow = !push_snapshot();
                end else if (c.button == BUTTON_MIDDLE) begin
                    r.grab_toggle = 1'b1;
                end
            end
            MODE_BTN_REL: begin
                if (c.button == BUTTON_RIGHT || c.button == BUTTON_LEFT) begin
                    btn_held = btn_held & ~btn_bit;
                    r.overflow = !push_snapshot();
                end
            end
            MODE_READ_MOUSE: begin
                r.mouse_x = c.old_x + acc_mx;
                r.mouse_y = c.old_y + acc_my;
                if (snap_count != 0) begin
                    snap = snap_ring[snap_head];
                    snap_head = (snap_head + 1) % BQ_DEPTH;
                    snap_count--;
                end else begin
                    snap = btn_held;
                end
                r.btn_report = BTN_MARK | {6'b0, snap};
                acc_mx = '0;
                acc_my = '0;
            end
            MODE_READ_KEY: begin
                if (key_count != 0) begin
                    r.key_code = key_ring[key_head];
                    key_head = (key_head + 1) % KQ_DEPTH;
                    key_count--;
                end
            end
            MODE_UPDATE: begin
                pending = key_count != 0 || snap_count != 0 || acc_mx != 0 || acc_my != 0;
                r.irq_request = pending && IRQ_LEVEL > c.cpu_mask_level
                                && IRQ_LEVEL > c.active_level;
            end
            MODE_MOTION: begin
                acc_mx = acc_mx + c.delta_x;
                acc_my = acc_my + c.delta_y;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // -------------------------------------------------------------------
    // checking
    // -------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic check_result(t_result got, t_result want);
        if (got.key_code !== want.key_code)
            report_mismatch("key_code", got.key_code, want.key_code);
        if (got.mouse_x !== want.mouse_x)
            report_mismatch("mouse_x", got.mouse_x, want.mouse_x);
        if (got.mouse_y !== want.mouse_y)
            report_mismatch("mouse_y", got.mouse_y, want.mouse_y);
        if (got.btn_report !== want.btn_report)
            report_mismatch("btn_report", got.btn_report, want.btn_report);
        if (got.irq_request !== want.irq_request)
            report_mismatch("irq_request", got.irq_request, want.irq_request);
        if (got.grab_toggle !== want.grab_toggle)
            report_mismatch("grab_toggle", got.grab_toggle, want.grab_toggle);
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
    endtask

    // sample at the rising edge: a result is checked before the command
    // taken at the same edge adds its own expectation
    always @(posedge i_clk) begin : monitor
        t_result pred;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", o_result, '0);
                else
                    check_result(o_result, pending_results.pop_front());
            end
            if (start && !busy) begin
                // shadow state always advances; a typed row overrides the value
                pred = predict_event(i_cmd);
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
            // watchdog counts cycles in which no transfer of either kind happens
            if (o_done || (start && !busy))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // -------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------

    function automatic t_cmd cmd_of(logic [2:0] mode, logic [6:0] scan, logic pressed,
                                    logic [1:0] button, logic [15:0] ox, logic [15:0] oy,
                                    logic [15:0] dx, logic [15:0] dy,
                                    logic [2:0] mask, logic [2:0] act);
        t_cmd c;
        c.mode           = mode;
        c.scan_code      = scan;
        c.pressed        = pressed;
        c.button         = button;
        c.old_x          = ox;
        c.old_y          = oy;
        c.delta_x        = dx;
        c.delta_y        = dy;
        c.cpu_mask_level = mask;
        c.active_level   = act;
        return c;
    endfunction

    function automatic t_result res_of(logic [7:0] key, logic [15:0] x, logic [15:0] y,
                                       logic [7:0] btn, logic irq, logic grab, logic ovf);
        t_result r;
        r.key_code    = key;
        r.mouse_x     = x;
        r.mouse_y     = y;
        r.btn_report  = btn;
        r.irq_request = irq;
        r.grab_toggle = grab;
        r.overflow    = ovf;
        return r;
    endfunction

    // every field random, mode drawn from the mix of the phase
    function automatic t_cmd random_cmd(t_phase ph);
        t_cmd        c;
        logic [95:0] rnd;
        int unsigned pick;
        rnd = {$urandom, $urandom, $urandom};
        c = rnd[$bits(t_cmd)-1:0];
        pick = $urandom_range(99);
        case (ph)
            PH_FILL: begin
                // mostly events, so both rings run full and overflow
                if (pick < 45)      c.mode = MODE_KEY;
                else if (pick < 65) c.mode = MODE_BTN_PRESS;
                else if (pick < 85) c.mode = MODE_BTN_REL;
                else if (pick < 90) c.mode = MODE_MOTION;
                else if (pick < 94) c.mode = MODE_UPDATE;
                else if (pick < 97) c.mode = MODE_READ_MOUSE;
                else                c.mode = MODE_READ_KEY;
            end
            PH_DRAIN: begin
                // mostly reads, so the rings empty and wrap
                if (pick < 40)      c.mode = MODE_READ_KEY;
                else if (pick < 80) c.mode = MODE_READ_MOUSE;
                else if (pick < 90) c.mode = MODE_UPDATE;
                else if (pick < 95) c.mode = MODE_MOTION;
                else                c.mode = MODE_KEY;
            end
            default: begin
                c.mode = 3'($urandom_range(7));
            end
        endcase
        // button events mostly name a button that changes the state
        if ((c.mode == MODE_BTN_PRESS || c.mode == MODE_BTN_REL) && $urandom_range(99) < 80)
            c.button = $urandom_range(1) ? BUTTON_LEFT : BUTTON_RIGHT;
        return c;
    endfunction

    // offer one command from the falling edge and hold it until the transfer
    task automatic send_cmd(t_cmd c, bit typed, t_result want, bit may_idle);
        @(negedge i_clk);
        while (may_idle && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= c;
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // hold off until every result in flight has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_dir_row dir_tab [$];
        int       sent;
        int       blk;
        int       blk_len;
        t_phase   ph;

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_cmd     = '0;
        cur_typed = 1'b0;
        cur_want  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reads and update on an empty block
        dir_tab.push_back('{cmd_of(MODE_READ_KEY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_READ_MOUSE, 0, 0, 0, 16'h7fff, 16'h8000, 0, 0, 0, 0),
                            1'b1, res_of(0, 16'h7fff, 16'h8000, BTN_MARK, 0, 0, 0)});
        dir_tab.push_back('{cmd_of(MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        // lowest press code and highest release code
        dir_tab.push_back('{cmd_of(MODE_KEY, 7'h00, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_KEY, 7'h7f, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        // interrupt just below the level, then each level at the limit
        dir_tab.push_back('{cmd_of(MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0, 4, 4),
                            1'b1, res_of(0, 0, 0, 0, 1, 0, 0)});
        dir_tab.push_back('{cmd_of(MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0, 5, 0), 1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 5), 1'b1, '0});
        // both codes back out in order, then an empty read
        dir_tab.push_back('{cmd_of(MODE_READ_KEY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_READ_KEY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                            1'b1, res_of(8'hff, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{cmd_of(MODE_READ_KEY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        // every button pressed, all but left released; middle press flags a grab
        dir_tab.push_back('{cmd_of(MODE_BTN_PRESS, 0, 0, BUTTON_RIGHT, 0, 0, 0, 0, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_BTN_PRESS, 0, 0, BUTTON_LEFT, 0, 0, 0, 0, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_BTN_PRESS, 0, 0, BUTTON_MIDDLE, 0, 0, 0, 0, 0, 0),
                            1'b1, res_of(0, 0, 0, 0, 0, 1, 0)});
        dir_tab.push_back('{cmd_of(MODE_BTN_PRESS, 0, 0, BUTTON_OTHER, 0, 0, 0, 0, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_BTN_REL, 0, 0, BUTTON_RIGHT, 0, 0, 0, 0, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_BTN_REL, 0, 0, BUTTON_MIDDLE, 0, 0, 0, 0, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_BTN_REL, 0, 0, BUTTON_OTHER, 0, 0, 0, 0, 0, 0),
                            1'b1, '0});
        // motion extremes, the second step wraps both sums
        dir_tab.push_back('{cmd_of(MODE_MOTION, 0, 0, 0, 0, 0, 16'h7fff, 16'h8000, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_MOTION, 0, 0, 0, 0, 0, 16'h0001, 16'hffff, 0, 0),
                            1'b1, '0});
        dir_tab.push_back('{cmd_of(MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0, 7, 7), 1'b1, '0});
        // snapshots come back oldest first, then the live state once empty
        dir_tab.push_back('{cmd_of(MODE_READ_MOUSE, 0, 0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0),
                            1'b0, '0});
        dir_tab.push_back('{cmd_of(MODE_READ_MOUSE, 0, 0, 0, 16'hffff, 16'h0001, 0, 0, 0, 0),
                            1'b0, '0});
        dir_tab.push_back('{cmd_of(MODE_READ_MOUSE, 0, 0, 0, 16'h8000, 16'h7fff, 0, 0, 0, 0),
                            1'b0, '0});
        dir_tab.push_back('{cmd_of(MODE_READ_MOUSE, 0, 0, 0, 16'h1234, 16'hfedc, 0, 0, 0, 0),
                            1'b0, '0});
        // unused mode with every other field at its top
        dir_tab.push_back('{cmd_of(MODE_NONE, 7'h7f, 1, BUTTON_OTHER, 16'hffff, 16'hffff,
                                   16'hffff, 16'hffff, 7, 7), 1'b1, '0});

        foreach (dir_tab[i])
            send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want, 1'b1);
        drain_results();

        // random blocks: the first two fill both rings past full, later
        // blocks pick a mix at random and sometimes wait for an empty pipe
        sent = 0;
        blk  = 0;
        while (sent < N_RANDOM) begin
            blk_len = $urandom_range(80, 160);
            ph = (blk < 2) ? PH_FILL : t_phase'($urandom_range(2));
            for (int k = 0; k < blk_len && sent < N_RANDOM; k++) begin
                send_cmd(random_cmd(ph), 1'b0, '0,
                         !(sent >= QUIET_FIRST && sent < QUIET_LAST));
                sent++;
            end
            if ($urandom_range(3) == 0)
                drain_results();
            blk++;
        end

        // wait out the last results plus a short margin
        drain_results();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), 0);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== keyboard_mouse_event_queue.f =====
sv/kmeq_pkg.sv
sv/kmeq_ring.sv
sv/keyboard_mouse_event_queue.sv
tb/tb_keyboard_mouse_event_queue.sv
